// File: hdl/csmw_pkg.sv
package csmw_pkg;

    localparam int MAX_ELEMS = 32;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_ELEMS);
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
    localparam int WT_W      = 7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_LOAD_RD,
        ST_LOAD_CAP,
        ST_COUNT_RD,
        ST_COUNT_CMP,
        ST_SKIP_RD,
        ST_SKIP_CMP,
        ST_NEXT,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

endpackage

// File: hdl/cycle_sort_min_writes.sv
// Cycle sort of one set of signed 32-bit values, in place, with a count of store writes.
// Input: a word is accepted at a rising edge with start high and busy low. Each accepted
// word stores value; one with is_last high ends the set and starts the sort. Words past
// the capacity of 32 entries are dropped and the set is flagged as overflowed.
// Loading takes one word per cycle while start is high; busy stays low until the word
// that ends the set. Sorting: busy stays high while the store is walked through a single
// read port with registered data, each element visited being read and then compared.
// Each cycle start loads its element, and every target search reads each following
// element and then skips the equal elements at the target, so a set already in order
// still has every element compared with all those that follow it.
// Output: each word is read in ST_EMIT_RD and shown in ST_EMIT_OUT for exactly one cycle
// with result_valid high, carrying last_out on the final word, write_total and overflow.
// The receiver cannot stall: every word on result_valid is taken as it comes.
// After the last result busy falls and the next set may start loading.
// Reset clears the control state and the counters; the store holds nothing defined and
// is only read where the current set has written it.
module cycle_sort_min_writes
    import csmw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     is_last,
    output logic                     result_valid,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     last_out,
    output logic [WT_W-1:0]          write_total,
    output logic                     overflow
);

    logic signed [DATA_W-1:0] mem [MAX_ELEMS];

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [WT_W-1:0]          wc_reg, wc_next;
    logic                     ov_reg, ov_next;
    logic [CNT_W-1:0]         start_reg, start_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic                     first_reg, first_next;
    logic signed [DATA_W-1:0] item_reg, item_next;
    logic signed [DATA_W-1:0] rdata_reg;

    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]         raddr;
    logic                     less;
    logic [CNT_W-1:0]         pos_inc;
    logic [CNT_W-1:0]         j_inc;

    assign less    = rdata_reg < item_reg;
    assign pos_inc = pos_reg + CNT_W'(less);
    assign j_inc   = j_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            wc_reg    <= '0;
            ov_reg    <= 1'b0;
            start_reg <= '0;
            pos_reg   <= '0;
            j_reg     <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            wc_reg    <= wc_next;
            ov_reg    <= ov_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            j_reg     <= j_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        wc_next    = wc_reg;
        ov_next    = ov_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        j_next     = j_reg;
        first_next = first_reg;
        item_next  = item_reg;
        we         = 1'b0;
        waddr      = fill_reg[IDX_W-1:0];
        wdata      = value;
        raddr      = pos_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (fill_reg < CNT_W'(MAX_ELEMS))
                    begin
                        we        = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ov_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                start_next = '0;
                j_next     = '0;
                if (fill_reg >= CNT_W'(2))
                begin
                    state_next = ST_LOAD_RD;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_LOAD_RD:
            begin
                raddr      = start_reg[IDX_W-1:0];
                state_next = ST_LOAD_CAP;
            end
            ST_LOAD_CAP:
            begin
                item_next  = rdata_reg;
                pos_next   = start_reg;
                j_next     = start_reg + CNT_W'(1);
                first_next = 1'b1;
                state_next = ST_COUNT_RD;
            end
            ST_COUNT_RD:
            begin
                raddr      = j_reg[IDX_W-1:0];
                state_next = ST_COUNT_CMP;
            end
            ST_COUNT_CMP:
            begin
                pos_next = pos_inc;
                j_next   = j_inc;
                if (j_inc < fill_reg)
                begin
                    state_next = ST_COUNT_RD;
                end
                else if (first_reg && (pos_inc == start_reg))
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_SKIP_RD;
                end
            end
            ST_SKIP_RD:
            begin
                if (pos_reg >= fill_reg)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    raddr      = pos_reg[IDX_W-1:0];
                    state_next = ST_SKIP_CMP;
                end
            end
            ST_SKIP_CMP:
            begin
                if (rdata_reg == item_reg)
                begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = ST_SKIP_RD;
                end
                else
                begin
                    // The held word goes to its place and the displaced word is carried on.
                    we         = 1'b1;
                    waddr      = pos_reg[IDX_W-1:0];
                    wdata      = item_reg;
                    item_next  = rdata_reg;
                    wc_next    = wc_reg + WT_W'(1);
                    first_next = 1'b0;
                    if (pos_reg == start_reg)
                    begin
                        state_next = ST_NEXT;
                    end
                    else
                    begin
                        pos_next   = start_reg;
                        j_next     = start_reg + CNT_W'(1);
                        state_next = ST_COUNT_RD;
                    end
                end
            end
            ST_NEXT:
            begin
                start_next = start_reg + CNT_W'(1);
                if ((start_reg + CNT_W'(2)) < fill_reg)
                begin
                    state_next = ST_LOAD_RD;
                end
                else
                begin
                    j_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                raddr      = j_reg[IDX_W-1:0];
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                j_next = j_inc;
                if (j_inc == fill_reg)
                begin
                    fill_next  = '0;
                    wc_next    = '0;
                    ov_next    = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = state_reg != ST_IDLE;
    assign result_valid = state_reg == ST_EMIT_OUT;
    assign sorted_value = rdata_reg;
    assign last_out     = j_inc == fill_reg;
    assign write_total  = wc_reg;
    assign overflow     = ov_reg;

endmodule

// File: dv/cycle_sort_min_writes_test.sv
module cycle_sort_min_writes_test
    import csmw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic [WT_W-1:0]          write_total;
        logic                     overflow;
    } sorted_word_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     is_last = 1'b0;
    logic                     busy;
    logic                     result_valid;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic [WT_W-1:0]          write_total;
    logic                     overflow;

    logic signed [DATA_W-1:0] set_store [MAX_ELEMS];
    int unsigned              set_fill = 0;
    bit                       set_overflowed = 1'b0;
    sorted_word_t             sorted_words [$];
    int unsigned              mismatch_count = 0;
    int unsigned              words_sent = 0;
    bit                       gaps_on = 1'b1;

    localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};

    cycle_sort_min_writes uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .is_last      (is_last),
        .result_valid (result_valid),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .write_total  (write_total),
        .overflow     (overflow)
    );

    always #1 clk = ~clk;

    function automatic int unsigned target_position(int unsigned first, int unsigned n,
                                                    logic signed [DATA_W-1:0] item);
        int unsigned pos;
        pos = first;
        for (int unsigned j = first + 1; j < n; j++)
        begin
            if (set_store[j] < item)
                pos++;
        end
        return pos;
    endfunction

    function automatic int unsigned skip_equal_values(int unsigned pos, int unsigned n,
                                                      logic signed [DATA_W-1:0] item);
        while (pos < n && set_store[pos] == item)
            pos++;
        return pos;
    endfunction

    function automatic int unsigned cycle_sort_set(int unsigned n);
        logic signed [DATA_W-1:0] item;
        logic signed [DATA_W-1:0] held;
        int unsigned              pos;
        int unsigned              writes;
        writes = 0;
        for (int unsigned first = 0; first + 1 < n; first++)
        begin
            item = set_store[first];
            pos = target_position(first, n, item);
            if (pos == first)
                continue;
            pos = skip_equal_values(pos, n, item);
            if (pos >= n)
                continue;
            if (pos != first)
            begin
                held = set_store[pos];
                set_store[pos] = item;
                item = held;
                writes++;
            end
            while (pos != first)
            begin
                pos = target_position(first, n, item);
                pos = skip_equal_values(pos, n, item);
                if (pos >= n)
                    break;
                if (item != set_store[pos])
                begin
                    held = set_store[pos];
                    set_store[pos] = item;
                    item = held;
                    writes++;
                end
            end
        end
        return writes;
    endfunction

    function automatic void take_word(logic signed [DATA_W-1:0] v, bit last);
        int unsigned  writes;
        sorted_word_t w;
        if (set_fill < MAX_ELEMS)
        begin
            set_store[set_fill] = v;
            set_fill++;
        end
        else
            set_overflowed = 1'b1;
        if (last)
        begin
            writes = cycle_sort_set(set_fill);
            for (int unsigned k = 0; k < set_fill; k++)
            begin
                w.sorted_value = set_store[k];
                w.last_out = (k + 1 == set_fill);
                w.write_total = writes[WT_W-1:0];
                w.overflow = set_overflowed;
                sorted_words.push_back(w);
            end
            set_fill = 0;
            set_overflowed = 1'b0;
        end
    endfunction

    task automatic send_word(input logic signed [DATA_W-1:0] v, input bit last);
        start <= 1'b1;
        value <= v;
        is_last <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        take_word(v, last);
        words_sent++;
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(int unsigned mode);
        logic signed [DATA_W-1:0] v;
        case (mode)
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 7)) - 3;
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = MIN_VAL;
                    1: v = MAX_VAL;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            default: v = $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 3));
        endcase
        return v;
    endfunction

    task automatic send_set(input int unsigned len, input int unsigned mode);
        for (int unsigned i = 0; i < len; i++)
            send_word(pick_value(mode), i + 1 == len);
    endtask

    task automatic test_single_extremes();
        send_word(MIN_VAL, 1'b1);
        send_word(MAX_VAL, 1'b1);
        send_word(MAX_VAL, 1'b0);
        send_word(MIN_VAL, 1'b1);
    endtask

    task automatic test_mixed_signs();
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(1, 1'b0);
        send_word(MIN_VAL, 1'b0);
        send_word(MAX_VAL, 1'b1);
    endtask

    task automatic test_duplicates();
        send_word(5, 1'b0);
        send_word(5, 1'b0);
        send_word(-3, 1'b0);
        send_word(5, 1'b0);
        send_word(-3, 1'b1);
        for (int i = 0; i < 4; i++)
            send_word(7, i == 3);
    endtask

    task automatic test_presorted();
        send_word(1, 1'b0);
        send_word(2, 1'b0);
        send_word(3, 1'b1);
    endtask

    // A set of exactly the capacity, then one that runs past it and is truncated.
    task automatic test_capacity();
        for (int i = 0; i < MAX_ELEMS; i++)
            send_word(MAX_ELEMS - i, i == MAX_ELEMS - 1);
        send_set(MAX_ELEMS + 2, 0);
    endtask

    task automatic test_random_sets();
        int unsigned len;
        int unsigned r;
        while (words_sent < 290)
        begin
            r = $urandom_range(0, 19);
            if (r < 14)
                len = $urandom_range(1, 8);
            else if (r < 18)
                len = $urandom_range(9, 20);
            else if (r == 18)
                len = $urandom_range(21, MAX_ELEMS);
            else
                len = $urandom_range(MAX_ELEMS + 1, MAX_ELEMS + 8);
            gaps_on = ($urandom_range(0, 3) != 0);
            send_set(len, $urandom_range(0, 3));
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        for (int i = 0; i < 5; i++)
            send_set($urandom_range(1, 6), $urandom_range(0, 3));
    endtask

    always @(posedge clk)
    begin
        sorted_word_t w;
        if (rst_n && result_valid === 1'b1)
        begin
            if (sorted_words.size() == 0)
            begin
                $error("sorted word %0d arrived with nothing expected", sorted_value);
                mismatch_count++;
            end
            else
            begin
                w = sorted_words.pop_front();
                if (sorted_value !== w.sorted_value)
                begin
                    $error("sorted_value: expected %0d, actual %0d",
                           w.sorted_value, sorted_value);
                    mismatch_count++;
                end
                if (last_out !== w.last_out)
                begin
                    $error("last_out: expected %0d, actual %0d", w.last_out, last_out);
                    mismatch_count++;
                end
                if (write_total !== w.write_total)
                begin
                    $error("write_total: expected %0d, actual %0d",
                           w.write_total, write_total);
                    mismatch_count++;
                end
                if (overflow !== w.overflow)
                begin
                    $error("overflow: expected %0d, actual %0d", w.overflow, overflow);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_extremes();
        test_mixed_signs();
        test_duplicates();
        test_presorted();
        test_capacity();
        test_random_sets();
        test_back_to_back();
        start <= 1'b0;
        while (sorted_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && sorted_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule
